// ----- rtl/log_grid_quadratic_interpolator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// log grid interpolator assertion macros
// concurrent assertion forms for the rtl files, used by lgqi_queue
// ----------------------------------------------------------------------------
`ifndef LOG_GRID_QUADRATIC_INTERPOLATOR_UNIT_MACROS_SVH
`define LOG_GRID_QUADRATIC_INTERPOLATOR_UNIT_MACROS_SVH

// condition must never hold out of reset
`define LGQI_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define LGQI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/lgqi_pkg.sv -----
// ----------------------------------------------------------------------------
// lgqi_pkg
// types and constants of the log grid quadratic interpolator
// ----------------------------------------------------------------------------
package lgqi_pkg;

    localparam int MAX_GRID    = 1023;
    localparam int CHANNELS    = 6;
    localparam int ROW_BITS    = $clog2(MAX_GRID + 1);
    localparam int CH_BITS     = 3;
    localparam int ADDR_W      = CH_BITS + ROW_BITS;
    localparam int TABLE_DEPTH = CHANNELS * (1 << ROW_BITS);
    localparam int QUEUE_DEPTH = 4;
    localparam int U_LIMIT     = 4 << 16;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_RANGE   = 2'd1,
        ERR_CHANNEL = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        CFG_LOG_LOWER  = 3'd0,
        CFG_LOG_UPPER  = 3'd1,
        CFG_LOG_STEP   = 3'd2,
        CFG_STEP_RECIP = 3'd3,
        CFG_GRID_COUNT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] log_lower;
        logic signed [31:0] log_upper;
        logic [30:0]        log_step;
        logic [31:0]        step_reciprocal;
        logic [9:0]         grid_count;
    } cfg_t;

    typedef struct packed {
        logic                kind;
        logic [CH_BITS-1:0]  channel;
        logic [ROW_BITS-1:0] entry_index;
        logic signed [31:0]  entry_value;
        err_t                error;
        logic [ROW_BITS-1:0] grid_i;
        logic                dt_neg;
        logic                dt_big;
        logic [31:0]         dt_mag;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/lgqi_ram.sv -----
// ----------------------------------------------------------------------------
// lgqi_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lgqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lgqi_front.sv -----
// ----------------------------------------------------------------------------
// lgqi_front
// accepts items, checks range and channel, finds grid index and offset
// ----------------------------------------------------------------------------
module lgqi_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lgqi_pkg::cfg_t         cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_kind,
    input  logic [2:0]             in_channel,
    input  logic [9:0]             in_entry_index,
    input  logic signed [31:0]     in_entry_value,
    input  logic signed [31:0]     in_log_t,
    input  lgqi_pkg::q_status_t    q_status,
    output logic                   push,
    output lgqi_pkg::item_t        push_item
);

    localparam int RB = lgqi_pkg::ROW_BITS;

    logic en;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    lgqi_pkg::item_t s1_reg, s2_reg, s3_reg, s4_reg;
    lgqi_pkg::item_t s1_next, s3_next;
    logic [31:0]   s1_d_reg, s2_d_reg, s3_d_reg, s4_d_reg;
    logic [RB-1:0] s1_n_reg, s2_n_reg;
    logic [23:0]   s2_q_reg;
    logic [40:0]   s4_sprod_reg;

    logic          oor;
    lgqi_pkg::err_t err_next;
    logic [32:0]   diff;
    logic [RB-1:0] n_next;
    logic [63:0]   qprod;
    logic [RB-1:0] nm1;
    logic [RB-1:0] i_next;
    logic [41:0]   dt;
    logic [41:0]   mag;

    assign en       = !s4_valid_reg || !q_status.full;
    assign in_ready = en;
    assign push     = s4_valid_reg && en;

    always_comb begin
        oor = (in_log_t < cfg.log_lower) || (in_log_t > cfg.log_upper);
        if (oor) begin
            err_next = lgqi_pkg::ERR_RANGE;
        end else if (32'(in_channel) >= lgqi_pkg::CHANNELS) begin
            err_next = lgqi_pkg::ERR_CHANNEL;
        end else begin
            err_next = lgqi_pkg::ERR_OK;
        end
        diff = {in_log_t[31], in_log_t} - {cfg.log_lower[31], cfg.log_lower};
        if (cfg.grid_count < 10'd2) begin
            n_next = RB'(2);
        end else if (32'(cfg.grid_count) > lgqi_pkg::MAX_GRID) begin
            n_next = RB'(lgqi_pkg::MAX_GRID);
        end else begin
            n_next = RB'(cfg.grid_count);
        end
        qprod = 64'(s1_d_reg) * 64'(cfg.step_reciprocal);
        nm1   = s2_n_reg - RB'(1);
        if (s2_q_reg >= 24'(nm1)) begin
            i_next = nm1;
        end else begin
            i_next = s2_q_reg[RB-1:0] + RB'(1);
        end
        dt  = {10'b0, s4_d_reg} - {1'b0, s4_sprod_reg};
        mag = dt[41] ? (42'd0 - dt) : dt;
    end

    always_comb begin
        s1_next             = '0;
        s1_next.kind        = in_kind;
        s1_next.channel     = in_channel;
        s1_next.entry_index = in_entry_index;
        s1_next.entry_value = in_entry_value;
        s1_next.error       = err_next;
        s3_next             = s2_reg;
        s3_next.grid_i      = i_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            s1_d_reg <= diff[31:0];
            s1_n_reg <= n_next;

            s2_reg   <= s1_reg;
            s2_d_reg <= s1_d_reg;
            s2_n_reg <= s1_n_reg;
            s2_q_reg <= qprod[63:40];

            s3_reg   <= s3_next;
            s3_d_reg <= s2_d_reg;

            s4_reg       <= s3_reg;
            s4_d_reg     <= s3_d_reg;
            s4_sprod_reg <= 41'(cfg.log_step) * 41'(s3_reg.grid_i);
        end
    end

    always_comb begin
        push_item        = s4_reg;
        push_item.dt_neg = dt[41];
        push_item.dt_big = |mag[41:32];
        push_item.dt_mag = mag[31:0];
    end

endmodule

// ----- rtl/lgqi_queue.sv -----
// ----------------------------------------------------------------------------
// lgqi_queue
// short register queue between the front and back parts
// ----------------------------------------------------------------------------
`include "log_grid_quadratic_interpolator_unit_macros.svh"

module lgqi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lgqi_pkg::item_t     push_item,
    input  logic                pop,
    output lgqi_pkg::item_t     head,
    output lgqi_pkg::q_status_t status
);

    localparam int PB = $clog2(lgqi_pkg::QUEUE_DEPTH);
    localparam int CB = $clog2(lgqi_pkg::QUEUE_DEPTH + 1);

    lgqi_pkg::item_t entries_reg [lgqi_pkg::QUEUE_DEPTH];
    logic [PB-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CB-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CB'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PB'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PB'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CB'(lgqi_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `LGQI_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && status.full)
    `LGQI_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && status.empty)
    `LGQI_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CB'(1))

endmodule

// ----- rtl/lgqi_back.sv -----
// ----------------------------------------------------------------------------
// lgqi_back
// table writes and reads, lagrange weights, weighted sum and output register
// ----------------------------------------------------------------------------
module lgqi_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  lgqi_pkg::cfg_t      cfg,
    input  lgqi_pkg::q_status_t q_status,
    input  lgqi_pkg::item_t     head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_flux,
    output lgqi_pkg::err_t      out_error
);

    localparam int AW = lgqi_pkg::ADDR_W;
    localparam int RB = lgqi_pkg::ROW_BITS;
    localparam int CB = lgqi_pkg::CH_BITS;

    logic en;
    logic ch_ok;
    logic [CB-1:0] rd_ch;
    logic [AW-1:0] raddr0, raddr1, raddr2, waddr;
    logic we;
    logic signed [31:0] f0, f1, f2;

    logic r1_valid_reg, r2_valid_reg, r3_valid_reg, r4_valid_reg, r5_valid_reg, r6_valid_reg;
    lgqi_pkg::err_t r1_err_reg, r2_err_reg, r3_err_reg, r4_err_reg, r5_err_reg, r6_err_reg;
    logic r1_neg_reg, r1_big_reg, r2_neg_reg, r2_big_reg;
    logic [31:0] r1_mag_reg;
    logic [63:0] r2_p_reg;
    logic signed [31:0] r2_f0_reg, r2_f1_reg, r2_f2_reg;
    logic signed [31:0] r3_f0_reg, r3_f1_reg, r3_f2_reg;
    logic signed [31:0] r4_f0_reg, r4_f1_reg, r4_f2_reg;
    logic signed [31:0] r5_f0_reg, r5_f1_reg, r5_f2_reg;
    logic signed [19:0] r3_u_reg, r4_u_reg;
    logic signed [39:0] r4_uu_reg;
    logic signed [21:0] r5_w0_reg, r5_w1_reg, r5_w2_reg;
    logic signed [53:0] r6_p0_reg, r6_p1_reg, r6_p2_reg;
    logic out_valid_reg;
    logic signed [31:0] out_flux_reg;
    lgqi_pkg::err_t out_err_reg;

    logic [64:0] p_round;
    logic [40:0] p_top;
    logic [18:0] umag;
    logic signed [19:0] u_next;
    logic signed [39:0] uh, a0, a1, a2;
    logic signed [55:0] sum, res;
    logic signed [31:0] flux_next;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && !q_status.empty;

    always_comb begin
        ch_ok  = 32'(head.channel) < lgqi_pkg::CHANNELS;
        rd_ch  = ch_ok ? head.channel : '0;
        raddr0 = {rd_ch, head.grid_i - RB'(1)};
        raddr1 = {rd_ch, head.grid_i};
        raddr2 = {rd_ch, head.grid_i + RB'(1)};
        waddr  = {head.channel, head.entry_index};
        we     = pop && head.kind && ch_ok;
    end

    lgqi_ram #(.WIDTH(32), .DEPTH(lgqi_pkg::TABLE_DEPTH)) u_ram0 (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(head.entry_value),
        .re(pop), .raddr(raddr0), .rdata(f0)
    );
    lgqi_ram #(.WIDTH(32), .DEPTH(lgqi_pkg::TABLE_DEPTH)) u_ram1 (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(head.entry_value),
        .re(pop), .raddr(raddr1), .rdata(f1)
    );
    lgqi_ram #(.WIDTH(32), .DEPTH(lgqi_pkg::TABLE_DEPTH)) u_ram2 (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(head.entry_value),
        .re(pop), .raddr(raddr2), .rdata(f2)
    );

    always_comb begin
        p_round = 65'(r2_p_reg) + (65'(1) << 23);
        p_top   = p_round[64:24];
        if (r2_big_reg || p_top > 41'(lgqi_pkg::U_LIMIT)) begin
            umag = 19'(lgqi_pkg::U_LIMIT);
        end else begin
            umag = p_top[18:0];
        end
        u_next = r2_neg_reg ? (20'sd0 - $signed({1'b0, umag})) : $signed({1'b0, umag});
        uh = 40'(r4_u_reg) <<< 16;
        a0 = r4_uu_reg - uh + 40'sd65536;
        a1 = (40'sd1 <<< 32) - r4_uu_reg + 40'sd32768;
        a2 = r4_uu_reg + uh + 40'sd65536;
        sum = 56'(r6_p0_reg) + 56'(r6_p1_reg) + 56'(r6_p2_reg) + 56'sd32768;
        res = sum >>> 16;
        if (res > 56'sd2147483647) begin
            flux_next = 32'sh7fffffff;
        end else if (res < -56'sd2147483648) begin
            flux_next = 32'sh80000000;
        end else begin
            flux_next = res[31:0];
        end
        if (r6_err_reg != lgqi_pkg::ERR_OK) begin
            flux_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            r3_valid_reg  <= 1'b0;
            r4_valid_reg  <= 1'b0;
            r5_valid_reg  <= 1'b0;
            r6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            r1_valid_reg  <= pop && !head.kind;
            r2_valid_reg  <= r1_valid_reg;
            r3_valid_reg  <= r2_valid_reg;
            r4_valid_reg  <= r3_valid_reg;
            r5_valid_reg  <= r4_valid_reg;
            r6_valid_reg  <= r5_valid_reg;
            out_valid_reg <= r6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_err_reg <= head.error;
            r1_neg_reg <= head.dt_neg;
            r1_big_reg <= head.dt_big;
            r1_mag_reg <= head.dt_mag;

            r2_err_reg <= r1_err_reg;
            r2_neg_reg <= r1_neg_reg;
            r2_big_reg <= r1_big_reg;
            r2_p_reg   <= 64'(r1_mag_reg) * 64'(cfg.step_reciprocal);
            r2_f0_reg  <= f0;
            r2_f1_reg  <= f1;
            r2_f2_reg  <= f2;

            r3_err_reg <= r2_err_reg;
            r3_u_reg   <= u_next;
            r3_f0_reg  <= r2_f0_reg;
            r3_f1_reg  <= r2_f1_reg;
            r3_f2_reg  <= r2_f2_reg;

            r4_err_reg <= r3_err_reg;
            r4_u_reg   <= r3_u_reg;
            r4_uu_reg  <= 40'(r3_u_reg) * 40'(r3_u_reg);
            r4_f0_reg  <= r3_f0_reg;
            r4_f1_reg  <= r3_f1_reg;
            r4_f2_reg  <= r3_f2_reg;

            r5_err_reg <= r4_err_reg;
            r5_w0_reg  <= 22'(a0 >>> 17);
            r5_w1_reg  <= 22'(a1 >>> 16);
            r5_w2_reg  <= 22'(a2 >>> 17);
            r5_f0_reg  <= r4_f0_reg;
            r5_f1_reg  <= r4_f1_reg;
            r5_f2_reg  <= r4_f2_reg;

            r6_err_reg <= r5_err_reg;
            r6_p0_reg  <= 54'(r5_f0_reg) * 54'(r5_w0_reg);
            r6_p1_reg  <= 54'(r5_f1_reg) * 54'(r5_w1_reg);
            r6_p2_reg  <= 54'(r5_f2_reg) * 54'(r5_w2_reg);

            out_err_reg  <= r6_err_reg;
            out_flux_reg <= flux_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_flux  = out_flux_reg;
    assign out_error = out_err_reg;

endmodule

// ----- rtl/log_grid_quadratic_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// log_grid_quadratic_interpolator_unit
// quadratic lagrange interpolation over six tables on an even log t grid
//
// channel   dir  handshake           payload
// s_        in   s_tvalid/s_tready   tuser kind, tdata query or table write
// m_        out  m_tvalid/m_tready   tdata flux_value, tuser error
// cfg_      in   cfg_valid/cfg_ready register index and write data
//
// one item per cycle sustained while m_tready holds; a query result passes the
// four front stages, the queue and the seven back stages
// (three table reads, reciprocal multiply, square, weights, products, sum)
// table contents are undefined after reset until written; no clearing pass
// reset is synchronous and active low; a stalled m_ side fills the queue
// before s_tready drops
// ----------------------------------------------------------------------------
module log_grid_quadratic_interpolator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // channel, entry_index, entry_value, log_t, zero fill
    input  logic [0:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // flux_value
    output logic [1:0]  m_tuser,   // error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lgqi_pkg::cfg_t      cfg_reg;
    lgqi_pkg::q_status_t q_status;
    lgqi_pkg::item_t     push_item, head;
    lgqi_pkg::err_t      out_error;
    logic                push, pop;
    logic signed [31:0]  out_flux;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log_lower       <= '0;
            cfg_reg.log_upper       <= '0;
            cfg_reg.log_step        <= '0;
            cfg_reg.step_reciprocal <= '0;
            cfg_reg.grid_count      <= 10'd2;
        end else if (cfg_valid && cfg_ready) begin
            case (lgqi_pkg::cfg_idx_t'(cfg_index))
                lgqi_pkg::CFG_LOG_LOWER:  cfg_reg.log_lower       <= cfg_data;
                lgqi_pkg::CFG_LOG_UPPER:  cfg_reg.log_upper       <= cfg_data;
                lgqi_pkg::CFG_LOG_STEP:   cfg_reg.log_step        <= cfg_data[30:0];
                lgqi_pkg::CFG_STEP_RECIP: cfg_reg.step_reciprocal <= cfg_data;
                lgqi_pkg::CFG_GRID_COUNT: cfg_reg.grid_count      <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    lgqi_front u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg_reg),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_kind(s_tuser[0]),
        .in_channel(s_tdata[2:0]),
        .in_entry_index(s_tdata[12:3]),
        .in_entry_value(s_tdata[44:13]),
        .in_log_t(s_tdata[76:45]),
        .q_status(q_status),
        .push(push),
        .push_item(push_item)
    );

    lgqi_queue u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_item(push_item),
        .pop(pop),
        .head(head),
        .status(q_status)
    );

    lgqi_back u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg_reg),
        .q_status(q_status),
        .head(head),
        .pop(pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_flux(out_flux),
        .out_error(out_error)
    );

    assign m_tdata = out_flux;
    assign m_tuser = out_error;

endmodule

// ----- sim/lgqi_flux_checker.sv -----
// ----------------------------------------------------------------------------
// lgqi_flux_checker
// watches the item, result and register channels of the interpolator, keeps
// its own tables and registers, predicts each query result and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lgqi_flux_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending_results
);

    typedef struct packed {
        logic signed [31:0] flux;
        lgqi_pkg::err_t     err;
    } flux_result_t;

    logic signed [31:0] flux_mem [lgqi_pkg::CHANNELS][lgqi_pkg::MAX_GRID+1];
    logic signed [31:0] reg_lower;
    logic signed [31:0] reg_upper;
    logic [30:0]        reg_step;
    logic [31:0]        reg_recip;
    logic [9:0]         reg_count;
    flux_result_t       expected_flux [$];

    function automatic flux_result_t interpolate(input logic [2:0] ch,
                                                 input logic signed [31:0] t);
        flux_result_t r;
        longint lo, hi, tl, d, dt, u, uu, uh, w0, w1, w2, sum, res, f0, f1, f2;
        longint unsigned n, q, i, mag, p, ud, ur;
        lo = longint'(reg_lower);
        hi = longint'(reg_upper);
        tl = longint'(t);
        r.flux = '0;
        if (tl < lo || tl > hi) begin
            r.err = lgqi_pkg::ERR_RANGE;
            return r;
        end
        if (ch >= lgqi_pkg::CHANNELS) begin
            r.err = lgqi_pkg::ERR_CHANNEL;
            return r;
        end
        r.err = lgqi_pkg::ERR_OK;
        n = 64'(reg_count);
        if (n < 2) n = 2;
        if (n > lgqi_pkg::MAX_GRID) n = lgqi_pkg::MAX_GRID;
        d = tl - lo;
        ud = d;
        ur = {32'b0, reg_recip};
        q = (ud * ur) >> 40;
        i = (q >= n - 1) ? n - 1 : q + 1;
        if (i < 1) i = 1;
        dt = d - longint'({33'b0, reg_step}) * longint'(i);
        mag = (dt < 0) ? -dt : dt;
        if (mag >= 64'h1_0000_0000) begin
            u = longint'(lgqi_pkg::U_LIMIT);
        end else begin
            p = (mag * ur + 64'd8388608) >> 24;
            u = (p > lgqi_pkg::U_LIMIT) ? longint'(lgqi_pkg::U_LIMIT) : longint'(p);
        end
        if (dt < 0) u = -u;
        uu = u * u;
        uh = u * 65536;
        w0 = (uu - uh + 65536) >>> 17;
        w1 = (64'sh1_0000_0000 - uu + 32768) >>> 16;
        w2 = (uu + uh + 65536) >>> 17;
        f0 = longint'(flux_mem[ch][10'(i - 1)]);
        f1 = longint'(flux_mem[ch][10'(i)]);
        f2 = longint'(flux_mem[ch][10'(i + 1)]);
        sum = f0 * w0 + f1 * w1 + f2 * w2;
        res = (sum + 32768) >>> 16;
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        r.flux = res[31:0];
        return r;
    endfunction

    assign pending_results = expected_flux.size();

    always @(posedge aclk) begin
        flux_result_t exp_r;
        logic [2:0]   ch;
        logic [9:0]   idx;
        if (!aresetn) begin
            reg_lower <= '0;
            reg_upper <= '0;
            reg_step  <= '0;
            reg_recip <= '0;
            reg_count <= 10'd2;
            fail_count <= 0;
            expected_flux.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lgqi_pkg::CFG_LOG_LOWER:  reg_lower <= cfg_data;
                    lgqi_pkg::CFG_LOG_UPPER:  reg_upper <= cfg_data;
                    lgqi_pkg::CFG_LOG_STEP:   reg_step  <= cfg_data[30:0];
                    lgqi_pkg::CFG_STEP_RECIP: reg_recip <= cfg_data;
                    lgqi_pkg::CFG_GRID_COUNT: reg_count <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                ch  = s_tdata[2:0];
                idx = s_tdata[12:3];
                if (s_tuser[0]) begin
                    if (ch < lgqi_pkg::CHANNELS) flux_mem[ch][idx] = s_tdata[44:13];
                end else begin
                    expected_flux.insert(expected_flux.size(),
                                         interpolate(ch, s_tdata[76:45]));
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_flux.size() == 0) begin
                    $display("%0t: result with no expected item: flux %0d error %0d",
                             $time, $signed(m_tdata), m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_flux.pop_front();
                    if (exp_r.flux !== m_tdata || exp_r.err !== m_tuser) begin
                        $display("%0t: expected flux %0d error %0d, got flux %0d error %0d",
                                 $time, exp_r.flux, exp_r.err, $signed(m_tdata), m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/tb_log_grid_quadratic_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_log_grid_quadratic_interpolator_unit
// runs the interpolator through several register settings, loads the tables
// before they are read, and sends directed and random queries and writes
// with random idling on both sides; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_log_grid_quadratic_interpolator_unit;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // channel, entry_index, entry_value, log_t, zero fill
    logic [0:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // flux_value
    logic [1:0]  m_tuser;   // error
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_results;

    bit          no_idle;
    int          hold_requests;
    int          hold_taken;
    int          hold_left;
    int          rx_wait;
    logic        m_taken;
    int          quiet_cycles;
    int          loaded_up_to [lgqi_pkg::CHANNELS];

    log_grid_quadratic_interpolator_unit dut (.*);

    lgqi_flux_checker checker_i (.*);

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver side
    always @(posedge aclk) m_taken <= m_tvalid && m_tready;

    always @(negedge aclk) begin
        if (hold_requests != hold_taken) begin
            hold_taken <= hold_requests;
            hold_left  <= 400;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (m_taken && !no_idle && $urandom_range(0, 6) != 0) begin
            rx_wait  <= int'($urandom_range(0, 5));
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("tb_log_grid_quadratic_interpolator_unit: errors");
            $finish;
        end
    end

    task automatic send_item(input logic kind, input logic [2:0] ch, input logic [9:0] idx,
                             input logic [31:0] val, input logic [31:0] t);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 6));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b0, t, val, idx, ch};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(input lgqi_pkg::cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic run_phase(input int phase, input int count);
        longint lo, hi, step, span;
        longint unsigned recip;
        int     n, n_eff, roll, ch_hi, k, c;
        logic [31:0] t;
        case (phase)
            0: begin
                lo = -64'sd2147483648; hi = 64'sd2147483647;
                step = 64'h7FFF_FFFF; recip = 0; n = 0;
            end
            1: begin
                step = 64'd1 << 21; n = 1023; lo = -(64'sd1 << 30);
                hi = lo + step * n; recip = (64'd1 << 40) / step;
            end
            2: begin
                lo = -64'sd1000000; hi = 64'sd3000000; step = 0;
                recip = 64'hFFFF_FFFF; n = 5;
            end
            default: begin
                step = longint'($urandom_range(1 << 18, 1 << 23));
                n = int'($urandom_range(2, 16));
                lo = longint'($signed($urandom_range(0, 1 << 26))) - (longint'(1) << 25);
                hi = lo + step * n;
                recip = (64'd1 << 40) / step;
                if ($urandom_range(0, 1)) recip = recip + $urandom_range(0, 8) - 4;
                if (phase == 7) n = 1;
            end
        endcase
        n_eff = (n < 2) ? 2 : n;
        ch_hi = (phase == 1) ? 0 : lgqi_pkg::CHANNELS - 1;
        write_reg(lgqi_pkg::CFG_LOG_LOWER, lo[31:0]);
        write_reg(lgqi_pkg::CFG_LOG_UPPER, hi[31:0]);
        write_reg(lgqi_pkg::CFG_LOG_STEP, step[31:0]);
        write_reg(lgqi_pkg::CFG_STEP_RECIP, recip[31:0]);
        write_reg(lgqi_pkg::CFG_GRID_COUNT, n[31:0]);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        no_idle = (phase == 4);
        // load every entry a query can reach
        for (c = 0; c <= ch_hi; c++) begin
            for (k = loaded_up_to[c] + 1; k <= n_eff; k++)
                send_item(1'b1, c[2:0], k[9:0], $urandom, $urandom);
            if (n_eff > loaded_up_to[c]) loaded_up_to[c] = n_eff;
        end
        if (phase == 3) hold_requests = hold_requests + 1;
        span = hi - lo;
        // range edges and bad channels
        send_item(1'b0, 3'd0, '0, '0, lo[31:0]);
        send_item(1'b0, ch_hi[2:0], '0, '0, hi[31:0]);
        if (lo > -64'sd2147483648) send_item(1'b0, 3'd0, '0, '0, lo[31:0] - 1);
        if (hi < 64'sd2147483647) send_item(1'b0, 3'd0, '0, '0, hi[31:0] + 1);
        send_item(1'b0, 3'd6, '0, '0, lo[31:0]);
        send_item(1'b0, 3'd7, '0, '0, hi[31:0]);
        for (k = 0; k < count; k++) begin
            roll = int'($urandom_range(0, 99));
            if (roll < 70) begin
                t = 32'(lo + longint'({32'b0, $urandom}) % (span + 1));
                send_item(1'b0, 3'($urandom_range(0, ch_hi)), 10'($urandom), $urandom, t);
            end else if (roll < 80) begin
                send_item(1'b0, 3'($urandom_range(0, 7)), 10'($urandom), $urandom,
                          $urandom);
            end else if (roll < 88) begin
                t = 32'(lo + longint'({32'b0, $urandom}) % (span + 1));
                send_item(1'b0, 3'($urandom_range(6, 7)), 10'($urandom), $urandom, t);
            end else if (roll < 94) begin
                c = int'($urandom_range(0, ch_hi));
                send_item(1'b1, c[2:0], 10'($urandom_range(0, loaded_up_to[c])), $urandom,
                          $urandom);
            end else begin
                send_item(1'b1, 3'($urandom_range(6, 7)), 10'($urandom), $urandom,
                          $urandom);
            end
        end
        drain_results();
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        hold_requests = 0;
        hold_taken    = 0;
        hold_left     = 0;
        rx_wait       = 0;
        for (int c = 0; c < lgqi_pkg::CHANNELS; c++) loaded_up_to[c] = -1;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        for (int p = 0; p < 8; p++) run_phase(p, (p == 1) ? 40 : 85);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("tb_log_grid_quadratic_interpolator_unit: clean");
        end else begin
            $display("tb_log_grid_quadratic_interpolator_unit: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/lgqi_pkg.sv
rtl/lgqi_ram.sv
rtl/lgqi_front.sv
rtl/lgqi_queue.sv
rtl/lgqi_back.sv
rtl/log_grid_quadratic_interpolator_unit.sv
sim/lgqi_flux_checker.sv
sim/tb_log_grid_quadratic_interpolator_unit.sv
